[src/vfv_pkg.sv]
`default_nettype none

package vfv_pkg;

	// Default geometry
	localparam int EDGE_DEF     = 16;
	localparam int ID_WIDTH_DEF = 16;

	// Command codes (s_axis_tuser)
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_MESH  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Result kinds (m_axis_tuser)
	localparam logic KIND_MESH  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_ORIGIN_Z = 2'd2;
	localparam logic [1:0] REG_SEE_ID   = 2'd3;

	localparam logic [15:0] SEE_ID_RESET = 16'd4;

	// Which cell the store port reads this step
	typedef enum logic [2:0] {
		NB_NONE, NB_CENTER, NB_YP, NB_YM, NB_XM, NB_XP, NB_ZM, NB_ZP
	} nb_t;

	// What the step does with last step's read data
	typedef enum logic [1:0] {
		CAP_NONE, CAP_ID, CAP_FACE
	} cap_t;

	typedef enum logic [1:0] {
		ACT_NONE, ACT_WRITE, ACT_EMIT_Q, ACT_EMIT_M
	} act_t;

	// Sequencing: fall through, dispatch on command, abort if out of range,
	// abort if the center cell is empty
	typedef enum logic [1:0] {
		BR_NONE, BR_DISPATCH, BR_NOT_OK, BR_EMPTY
	} br_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		nb_t        rd_sel;
		cap_t       cap;
		logic [2:0] face;
		act_t       act;
		br_t        br;
		pc_t        next;
	} ucode_t;

	// Program entry points
	localparam pc_t PC_IDLE      = 4'd0;
	localparam pc_t PC_LOAD      = 4'd1;
	localparam pc_t PC_QRY       = 4'd2;
	localparam pc_t PC_QRY_EMIT  = 4'd3;
	localparam pc_t PC_MESH      = 4'd4;
	localparam pc_t PC_MESH_ID   = 4'd5;
	localparam pc_t PC_MESH_F0   = 4'd6;
	localparam pc_t PC_MESH_F1   = 4'd7;
	localparam pc_t PC_MESH_F2   = 4'd8;
	localparam pc_t PC_MESH_F3   = 4'd9;
	localparam pc_t PC_MESH_F4   = 4'd10;
	localparam pc_t PC_MESH_EMIT = 4'd11;

	// Face slots, lowest first: top, bottom, left, right, rear (front is live)
	localparam logic [2:0] F_TOP    = 3'd0;
	localparam logic [2:0] F_BOTTOM = 3'd1;
	localparam logic [2:0] F_LEFT   = 3'd2;
	localparam logic [2:0] F_RIGHT  = 3'd3;
	localparam logic [2:0] F_REAR   = 3'd4;

	// Control store
	function automatic ucode_t ucode(input pc_t pc);
		ucode_t w;
		w.rd_sel = NB_NONE;
		w.cap    = CAP_NONE;
		w.face   = F_TOP;
		w.act    = ACT_NONE;
		w.br     = BR_NONE;
		w.next   = PC_IDLE;
		case (pc)
			PC_IDLE: begin
				w.br = BR_DISPATCH;
			end
			PC_LOAD: begin
				w.rd_sel = NB_CENTER;
				w.act    = ACT_WRITE;
			end
			PC_QRY: begin
				w.rd_sel = NB_CENTER;
				w.next   = PC_QRY_EMIT;
			end
			PC_QRY_EMIT: begin
				w.act = ACT_EMIT_Q;
			end
			PC_MESH: begin
				w.rd_sel = NB_CENTER;
				w.br     = BR_NOT_OK;
				w.next   = PC_MESH_ID;
			end
			PC_MESH_ID: begin
				w.rd_sel = NB_YP;
				w.cap    = CAP_ID;
				w.br     = BR_EMPTY;
				w.next   = PC_MESH_F0;
			end
			PC_MESH_F0: begin
				w.rd_sel = NB_YM;
				w.cap    = CAP_FACE;
				w.face   = F_TOP;
				w.next   = PC_MESH_F1;
			end
			PC_MESH_F1: begin
				w.rd_sel = NB_XM;
				w.cap    = CAP_FACE;
				w.face   = F_BOTTOM;
				w.next   = PC_MESH_F2;
			end
			PC_MESH_F2: begin
				w.rd_sel = NB_XP;
				w.cap    = CAP_FACE;
				w.face   = F_LEFT;
				w.next   = PC_MESH_F3;
			end
			PC_MESH_F3: begin
				w.rd_sel = NB_ZM;
				w.cap    = CAP_FACE;
				w.face   = F_RIGHT;
				w.next   = PC_MESH_F4;
			end
			PC_MESH_F4: begin
				w.rd_sel = NB_ZP;
				w.cap    = CAP_FACE;
				w.face   = F_REAR;
				w.next   = PC_MESH_EMIT;
			end
			PC_MESH_EMIT: begin
				w.act = ACT_EMIT_M;
			end
			default: begin
				w.next = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/voxel_face_visibility.sv]
// Sequence: a query reads its cell and then emits its result; a mesh record is emitted once
//   the cell and its six neighbors are read one per cycle from the single-port cell store.
// Throughput: one item at a time; the next transfer is taken only when the sequencer is idle again.
//   A mesh ends early on an out-of-range position or an empty cell; the unused code leaves it idle.
//   A result held by the sink stalls the sequencer at its emit step.
// Reset: arst_n clears the sequencer, output valid, origins (0) and see-through id (4).
`default_nettype none

module voxel_face_visibility #(
	parameter int EDGE     = vfv_pkg::EDGE_DEF,
	parameter int ID_WIDTH = vfv_pkg::ID_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input items
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [39:0]  s_axis_tdata,  // pos_x, pos_y, pos_z, block_id
	input  wire logic [1:0]   s_axis_tuser,  // command
	// result items
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [119:0]      m_axis_tdata,  // world_x, world_y, world_z, cell_id,
	                                         // face_top, face_bottom, face_left,
	                                         // face_right, face_rear, face_front, 2'b0
	output logic [0:0]        m_axis_tuser,  // kind
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	localparam int DEPTH = EDGE * EDGE * EDGE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (EDGE > 1) ? $clog2(EDGE) : 1;
	localparam logic [7:0] EDGE_C = 8'(EDGE);

	// Configuration registers
	logic [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [15:0] see_id_q;

	// Item registers
	logic [7:0]          pos_x_q, pos_y_q, pos_z_q;
	logic [15:0]         bid_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [4:0]          faces_q;
	logic                rd_ok_q;

	// Sequencer
	vfv_pkg::pc_t    pc_q, pc_nxt;
	vfv_pkg::ucode_t uc;

	// Cell store
	logic [ID_WIDTH-1:0] store_q [DEPTH];
	logic [ID_WIDTH-1:0] rdata_q;
	logic [AW-1:0]       mem_addr;
	logic                mem_we, mem_re;

	// Output register
	logic         out_valid_q;
	logic [119:0] out_data_q;
	logic         out_kind_q;

	logic s_xfer, stall, emit_go, pos_ok, occ, face_front;
	logic signed [8:0] nx, ny, nz, dx, dy, dz;
	logic nb_ok;
	logic signed [ID_WIDTH-1:0] id_s, rd_s;
	logic [15:0] id_ext, rd_ext;
	logic [31:0] wx, wy, wz;

	assign uc            = vfv_pkg::ucode(pc_q);
	assign s_axis_tready = (pc_q == vfv_pkg::PC_IDLE);
	assign s_xfer        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Emit steps wait for the output register to free up
	assign stall = ((uc.act == vfv_pkg::ACT_EMIT_Q) || (uc.act == vfv_pkg::ACT_EMIT_M)) &&
	               out_valid_q && !m_axis_tready;
	assign emit_go = ((uc.act == vfv_pkg::ACT_EMIT_Q) || (uc.act == vfv_pkg::ACT_EMIT_M)) &&
	                 !stall;

	// Neighbor offset for this step's read
	always_comb begin
		dx = 9'sd0;
		dy = 9'sd0;
		dz = 9'sd0;
		case (uc.rd_sel)
			vfv_pkg::NB_YP: dy = 9'sd1;
			vfv_pkg::NB_YM: dy = -9'sd1;
			vfv_pkg::NB_XM: dx = -9'sd1;
			vfv_pkg::NB_XP: dx = 9'sd1;
			vfv_pkg::NB_ZM: dz = -9'sd1;
			vfv_pkg::NB_ZP: dz = 9'sd1;
			default: ;
		endcase
	end

	assign nx = $signed({pos_x_q[7], pos_x_q}) + dx;
	assign ny = $signed({pos_y_q[7], pos_y_q}) + dy;
	assign nz = $signed({pos_z_q[7], pos_z_q}) + dz;

	assign nb_ok = !nx[8] && (nx[7:0] < EDGE_C) &&
	               !ny[8] && (ny[7:0] < EDGE_C) &&
	               !nz[8] && (nz[7:0] < EDGE_C);

	assign pos_ok = !pos_x_q[7] && (pos_x_q < EDGE_C) &&
	                !pos_y_q[7] && (pos_y_q < EDGE_C) &&
	                !pos_z_q[7] && (pos_z_q < EDGE_C);

	// Cell address (y*EDGE + x)*EDGE + z
	assign mem_addr = (AW'(ny[CW-1:0]) * AW'(EDGE) + AW'(nx[CW-1:0])) * AW'(EDGE) +
	                  AW'(nz[CW-1:0]);
	assign mem_we   = (uc.act == vfv_pkg::ACT_WRITE) && pos_ok;
	assign mem_re   = (uc.rd_sel != vfv_pkg::NB_NONE) && nb_ok && !mem_we;

	// Single-port cell store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_addr] <= bid_q[ID_WIDTH-1:0];
		end else if (mem_re) begin
			rdata_q <= store_q[mem_addr];
		end
	end

	// Last read hides a face only if in bounds and opaque
	assign occ = rd_ok_q && (rdata_q != '0) && (rdata_q != see_id_q[ID_WIDTH-1:0]);
	assign face_front = !occ;

	assign id_s   = id_q;
	assign rd_s   = rdata_q;
	assign id_ext = 16'(id_s);
	assign rd_ext = 16'(rd_s);

	assign wx = {{24{pos_x_q[7]}}, pos_x_q} + origin_x_q;
	assign wy = {{24{pos_y_q[7]}}, pos_y_q} + origin_y_q;
	assign wz = {{24{pos_z_q[7]}}, pos_z_q} + origin_z_q;

	// Next step
	always_comb begin
		pc_nxt = uc.next;
		case (uc.br)
			vfv_pkg::BR_DISPATCH: begin
				pc_nxt = vfv_pkg::PC_IDLE;
				if (s_xfer) begin
					case (s_axis_tuser)
						vfv_pkg::CMD_LOAD:  pc_nxt = vfv_pkg::PC_LOAD;
						vfv_pkg::CMD_MESH:  pc_nxt = vfv_pkg::PC_MESH;
						vfv_pkg::CMD_QUERY: pc_nxt = vfv_pkg::PC_QRY;
						default:            pc_nxt = vfv_pkg::PC_IDLE;
					endcase
				end
			end
			vfv_pkg::BR_NOT_OK: pc_nxt = pos_ok ? uc.next : vfv_pkg::PC_IDLE;
			vfv_pkg::BR_EMPTY:  pc_nxt = (rdata_q == '0) ? vfv_pkg::PC_IDLE : uc.next;
			default:            pc_nxt = stall ? pc_q : uc.next;
		endcase
	end

	// Sequencer state, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= vfv_pkg::PC_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_kind_q  <= vfv_pkg::KIND_MESH;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			origin_z_q  <= '0;
			see_id_q    <= vfv_pkg::SEE_ID_RESET;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			bid_q       <= '0;
			id_q        <= '0;
			faces_q     <= '0;
			rd_ok_q     <= 1'b0;
		end else begin
			pc_q <= pc_nxt;

			// config writes
			if (cfg_valid) begin
				case (cfg_index)
					vfv_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
					vfv_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data;
					vfv_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data;
					vfv_pkg::REG_SEE_ID:   see_id_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			// input transfer
			if (s_xfer) begin
				pos_x_q <= s_axis_tdata[7:0];
				pos_y_q <= s_axis_tdata[15:8];
				pos_z_q <= s_axis_tdata[23:16];
				bid_q   <= s_axis_tdata[39:24];
			end

			if (uc.rd_sel != vfv_pkg::NB_NONE) begin
				rd_ok_q <= nb_ok;
			end

			// capture read data
			case (uc.cap)
				vfv_pkg::CAP_ID:   id_q <= rdata_q;
				vfv_pkg::CAP_FACE: faces_q[uc.face] <= !occ;
				default: ;
			endcase

			// output register
			if (emit_go) begin
				out_valid_q <= 1'b1;
				if (uc.act == vfv_pkg::ACT_EMIT_M) begin
					out_kind_q <= vfv_pkg::KIND_MESH;
					out_data_q <= {2'b00, face_front, faces_q, id_ext, wz, wy, wx};
				end else begin
					out_kind_q <= vfv_pkg::KIND_QUERY;
					out_data_q <= {8'd0, (rd_ok_q ? rd_ext : 16'd0), 96'd0};
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	// A result appears only out of an emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
		($past(uc.act) == vfv_pkg::ACT_EMIT_Q) || ($past(uc.act) == vfv_pkg::ACT_EMIT_M))
		else $error("result valid without emit step");

	// Mesh records only for non-empty cells
	a_mesh_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && (uc.act == vfv_pkg::ACT_EMIT_M)) |=> (m_axis_tdata[111:96] != 16'd0))
		else $error("mesh record for empty cell");

	// A mesh command enters the mesh program
	a_mesh_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(s_xfer && (s_axis_tuser == vfv_pkg::CMD_MESH)) |=> (pc_q == vfv_pkg::PC_MESH))
		else $error("mesh command not dispatched");

	// Store writes only from an in-range load step
	a_write_load: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((pc_q == vfv_pkg::PC_LOAD) && $past(s_xfer)))
		else $error("store write outside load");

endmodule

`default_nettype wire

[dv/voxel_face_visibility_tb.sv]
`timescale 1ns / 100ps

module voxel_face_visibility_tb;

	// Command code the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SECTION = 16;
	localparam int CELLS = SECTION * SECTION * SECTION;
	// Loads retire without a result
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic        kind;
		logic [31:0] wx;
		logic [31:0] wy;
		logic [31:0] wz;
		logic [15:0] id;
		logic        top;
		logic        bottom;
		logic        left;
		logic        right;
		logic        rear;
		logic        front;
	} cull_rec_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [39:0]   s_axis_tdata = '0;   // pos_x, pos_y, pos_z, block_id
	logic [1:0]    s_axis_tuser = '0;   // command
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [119:0]  m_axis_tdata;        // world_x, world_y, world_z, cell_id, six faces
	logic [0:0]    m_axis_tuser;        // kind
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = '0;
	logic [31:0]   cfg_data = '0;

	// Local copy of the section and registers
	logic [15:0]   cell_ids [0:CELLS-1];
	bit            cell_loaded [0:CELLS-1];
	int            loaded_cells [$];
	logic [31:0]   org_x = '0;
	logic [31:0]   org_y = '0;
	logic [31:0]   org_z = '0;
	logic [15:0]   see_id = vfv_pkg::SEE_ID_RESET;

	cull_rec_t     expected_records [$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_counted = 0;
	int n_loads = 0, n_meshes = 0, n_queries = 0, n_ignored = 0;
	int n_mesh_checked = 0, n_query_checked = 0, n_settings = 0;

	voxel_face_visibility DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------- model
	function automatic bit coord_ok(int x, int y, int z);
		return x >= 0 && x < SECTION && y >= 0 && y < SECTION && z >= 0 && z < SECTION;
	endfunction

	function automatic int cell_addr(int x, int y, int z);
		return (y * SECTION + x) * SECTION + z;
	endfunction

	// Neighbor offset for direction d (+y, -y, -x, +x, -z, +z) on one axis
	function automatic int dir_off(int d, int axis);
		case (d)
			0: return (axis == 1) ? 1 : 0;
			1: return (axis == 1) ? -1 : 0;
			2: return (axis == 0) ? -1 : 0;
			3: return (axis == 0) ? 1 : 0;
			4: return (axis == 2) ? -1 : 0;
			default: return (axis == 2) ? 1 : 0;
		endcase
	endfunction

	// Occluding neighbor: inside the section, not empty, not see-through
	function automatic bit hides_face(int x, int y, int z);
		logic [15:0] id;
		if (!coord_ok(x, y, z))
			return 1'b0;
		id = cell_ids[cell_addr(x, y, z)];
		return id != 16'd0 && id != see_id;
	endfunction

	function automatic bit mesh_ready(int x, int y, int z);
		int d, nx, ny, nz;
		if (!coord_ok(x, y, z) || !cell_loaded[cell_addr(x, y, z)])
			return 1'b0;
		for (d = 0; d < 6; d++) begin
			nx = x + dir_off(d, 0);
			ny = y + dir_off(d, 1);
			nz = z + dir_off(d, 2);
			if (coord_ok(nx, ny, nz) && !cell_loaded[cell_addr(nx, ny, nz)])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Update the section copy for one accepted item and queue its result, if any
	function automatic void predict_culling(logic [1:0] cmd, logic [7:0] px, logic [7:0] py,
			logic [7:0] pz, logic [15:0] bid);
		int x, y, z, a;
		bit ok;
		cull_rec_t r;
		x = $signed(px);
		y = $signed(py);
		z = $signed(pz);
		ok = coord_ok(x, y, z);
		a = ok ? cell_addr(x, y, z) : 0;
		r = '0;
		if (cmd == vfv_pkg::CMD_LOAD && ok) begin
			cell_ids[a] = bid;
			if (!cell_loaded[a]) begin
				cell_loaded[a] = 1'b1;
				loaded_cells.push_back(a);
			end
			n_loads++;
			items_counted++;
		end else if (cmd == vfv_pkg::CMD_QUERY) begin
			r.kind = vfv_pkg::KIND_QUERY;
			if (ok)
				r.id = cell_ids[a];
			expected_records.push_back(r);
			n_queries++;
			items_counted++;
		end else if (cmd == vfv_pkg::CMD_MESH && ok) begin
			n_meshes++;
			items_counted++;
			if (cell_ids[a] != 16'd0) begin
				r.kind   = vfv_pkg::KIND_MESH;
				r.wx     = org_x + 32'(x);
				r.wy     = org_y + 32'(y);
				r.wz     = org_z + 32'(z);
				r.id     = cell_ids[a];
				r.top    = !hides_face(x, y + 1, z);
				r.bottom = !hides_face(x, y - 1, z);
				r.left   = !hides_face(x - 1, y, z);
				r.right  = !hides_face(x + 1, y, z);
				r.rear   = !hides_face(x, y, z - 1);
				r.front  = !hides_face(x, y, z + 1);
				expected_records.push_back(r);
			end
		end else begin
			n_ignored++;
		end
	endfunction

	// ---------------------------------------------------------------- drivers
	always @(negedge clk)
		m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(logic [1:0] cmd, logic [7:0] px, logic [7:0] py, logic [7:0] pz,
			logic [15:0] bid);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {bid, pz, py, px};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_culling(cmd, px, py, pz, bid);
		@(negedge clk);
	endtask

	// Hold the input side until every queued result is out, then settle
	task automatic wait_results(int extra);
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_records.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			vfv_pkg::REG_ORIGIN_X: org_x = val;
			vfv_pkg::REG_ORIGIN_Y: org_y = val;
			vfv_pkg::REG_ORIGIN_Z: org_z = val;
			vfv_pkg::REG_SEE_ID:   see_id = val[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_registers(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [15:0] see);
		wait_results(SETTLE_CYCLES);
		write_reg(vfv_pkg::REG_ORIGIN_X, ox);
		write_reg(vfv_pkg::REG_ORIGIN_Y, oy);
		write_reg(vfv_pkg::REG_ORIGIN_Z, oz);
		write_reg(vfv_pkg::REG_SEE_ID, {{16{see[15]}}, see});
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// ---------------------------------------------------------------- checker
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		cull_rec_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind   = m_axis_tuser[0];
			got.wx     = m_axis_tdata[31:0];
			got.wy     = m_axis_tdata[63:32];
			got.wz     = m_axis_tdata[95:64];
			got.id     = m_axis_tdata[111:96];
			got.top    = m_axis_tdata[112];
			got.bottom = m_axis_tdata[113];
			got.left   = m_axis_tdata[114];
			got.right  = m_axis_tdata[115];
			got.rear   = m_axis_tdata[116];
			got.front  = m_axis_tdata[117];
			if (expected_records.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got kind %b data %h",
					$time, got.kind, m_axis_tdata);
				errors++;
			end else begin
				want = expected_records.pop_front();
				check_field("kind", 32'(want.kind), 32'(got.kind));
				check_field("world_x", want.wx, got.wx);
				check_field("world_y", want.wy, got.wy);
				check_field("world_z", want.wz, got.wz);
				check_field("cell_id", 32'(want.id), 32'(got.id));
				check_field("face_top", 32'(want.top), 32'(got.top));
				check_field("face_bottom", 32'(want.bottom), 32'(got.bottom));
				check_field("face_left", 32'(want.left), 32'(got.left));
				check_field("face_right", 32'(want.right), 32'(got.right));
				check_field("face_rear", 32'(want.rear), 32'(got.rear));
				check_field("face_front", 32'(want.front), 32'(got.front));
				if (want.kind == vfv_pkg::KIND_MESH)
					n_mesh_checked++;
				else
					n_query_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic int rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return 0;
		if (r < 40)
			return SECTION - 1;
		return $urandom_range(SECTION - 1);
	endfunction

	function automatic logic [15:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 16'd0;
		if (r < 40)
			return see_id;
		if (r < 50)
			return 16'd4;
		if (r < 65)
			return 16'($urandom_range(1, 8));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_origin();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 32'h7FFF_FFFF;
		if (r < 30)
			return 32'h8000_0000;
		if (r < 40)
			return 32'h0;
		if (r < 50)
			return 32'hFFFF_FFFF;
		if (r < 60)
			return 32'h7FFF_FFF0 + 32'($urandom_range(15));
		return $urandom;
	endfunction

	function automatic logic [15:0] rand_see();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return 16'd4;
		if (r < 35)
			return 16'd0;
		if (r < 45)
			return 16'h8000;
		if (r < 55)
			return 16'h7FFF;
		if (r < 65)
			return 16'hFFFF;
		if (r < 85)
			return 16'($urandom_range(1, 8));
		return 16'($urandom);
	endfunction

	// Fill a cell and its neighborhood with random ids, then mesh it
	task automatic build_and_mesh();
		int cx, cy, cz, nx, ny, nz, d;
		logic [15:0] cid;
		cx = rand_coord();
		cy = rand_coord();
		cz = rand_coord();
		cid = pick_id();
		if (cid == 16'd0 && $urandom_range(99) >= 10)
			cid = 16'($urandom_range(1, 65535));
		send_item(vfv_pkg::CMD_LOAD, 8'(cx), 8'(cy), 8'(cz), cid);
		for (d = 0; d < 6; d++) begin
			nx = cx + dir_off(d, 0);
			ny = cy + dir_off(d, 1);
			nz = cz + dir_off(d, 2);
			if (coord_ok(nx, ny, nz)
					&& (!cell_loaded[cell_addr(nx, ny, nz)] || $urandom_range(1) == 1))
				send_item(vfv_pkg::CMD_LOAD, 8'(nx), 8'(ny), 8'(nz), pick_id());
		end
		send_item(vfv_pkg::CMD_MESH, 8'(cx), 8'(cy), 8'(cz), 16'($urandom));
		if ($urandom_range(99) < 30)
			send_item(vfv_pkg::CMD_QUERY, 8'(cx), 8'(cy), 8'(cz), 16'($urandom));
	endtask

	// Re-mesh a cell whose neighborhood is fully loaded, or query a loaded cell
	task automatic revisit_cell(bit do_mesh);
		int a, tries;
		for (tries = 0; tries < 6; tries++) begin
			a = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
			if (!do_mesh || mesh_ready((a >> 4) & 15, a >> 8, a & 15)) begin
				send_item(do_mesh ? vfv_pkg::CMD_MESH : vfv_pkg::CMD_QUERY,
					8'((a >> 4) & 15), 8'(a >> 8), 8'(a & 15), 16'($urandom));
				return;
			end
		end
	endtask

	// Out-of-range positions and the unused command code
	task automatic send_noise();
		logic [7:0] px, py, pz;
		int r;
		px = $urandom_range(1) ? 8'($urandom) : 8'(rand_coord());
		py = $urandom_range(1) ? 8'($urandom) : 8'(rand_coord());
		pz = $urandom_range(1) ? 8'($urandom) : 8'(rand_coord());
		if (coord_ok($signed(px), $signed(py), $signed(pz)))
			px = 8'($urandom_range(16, 255));
		r = $urandom_range(99);
		if (r < 40)
			send_item(vfv_pkg::CMD_LOAD, px, py, pz, 16'($urandom));
		else if (r < 70)
			send_item(vfv_pkg::CMD_MESH, px, py, pz, 16'($urandom));
		else if (r < 85)
			send_item(vfv_pkg::CMD_QUERY, px, py, pz, 16'($urandom));
		else
			send_item(CMD_UNUSED, px, py, pz, 16'($urandom));
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_directed_cases();
		// corner cell: occluder above, see-through right, empty front
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd0, 8'd0, 16'h7FFF);
		send_item(vfv_pkg::CMD_LOAD, 8'd1, 8'd0, 8'd0, 16'd4);
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd1, 8'd0, 16'h8000);
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd0, 8'd1, 16'd0);
		send_item(vfv_pkg::CMD_MESH, 8'd0, 8'd0, 8'd0, 16'h0000);
		// opposite corner, fully boxed in from the inside
		send_item(vfv_pkg::CMD_LOAD, 8'd15, 8'd15, 8'd15, 16'hFFFF);
		send_item(vfv_pkg::CMD_LOAD, 8'd14, 8'd15, 8'd15, 16'd1);
		send_item(vfv_pkg::CMD_LOAD, 8'd15, 8'd14, 8'd15, 16'd2);
		send_item(vfv_pkg::CMD_LOAD, 8'd15, 8'd15, 8'd14, 16'd3);
		send_item(vfv_pkg::CMD_MESH, 8'd15, 8'd15, 8'd15, 16'hFFFF);
		// mesh of an empty cell whose neighbors are loaded
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd1, 8'd1, 16'd9);
		send_item(vfv_pkg::CMD_LOAD, 8'd1, 8'd0, 8'd1, 16'd0);
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd0, 8'd2, 16'd4);
		send_item(vfv_pkg::CMD_MESH, 8'd0, 8'd0, 8'd1, 16'h0000);
		// ignored items that must not disturb the store
		send_item(vfv_pkg::CMD_LOAD, 8'd16, 8'd0, 8'd0, 16'h1234);
		send_item(vfv_pkg::CMD_LOAD, 8'd0, 8'd0, 8'hFF, 16'h5678);
		send_item(vfv_pkg::CMD_MESH, 8'd127, 8'd0, 8'd0, 16'h0000);
		send_item(vfv_pkg::CMD_MESH, 8'd0, 8'h80, 8'd0, 16'h0000);
		send_item(CMD_UNUSED, 8'd0, 8'd0, 8'd0, 16'd5);
		// queries, in and out of range
		send_item(vfv_pkg::CMD_QUERY, 8'd0, 8'd0, 8'd0, 16'h0000);
		send_item(vfv_pkg::CMD_QUERY, 8'd0, 8'd0, 8'd1, 16'h0000);
		send_item(vfv_pkg::CMD_QUERY, 8'd15, 8'd15, 8'd15, 16'hFFFF);
		send_item(vfv_pkg::CMD_QUERY, 8'h80, 8'd127, 8'd0, 16'h0000);
		send_item(vfv_pkg::CMD_QUERY, 8'd16, 8'hFF, 8'd127, 16'h0000);
	endtask

	// Origin and see-through extremes against the two corner cells
	task automatic test_register_writes();
		int i;
		for (i = 0; i < 5; i++) begin
			case (i)
				0: load_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h8000);
				1: load_registers(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'd1);
				2: load_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
				3: load_registers(32'hFFFF_FFF1, 32'h0, 32'h7FFF_FFF1, 16'h7FFF);
				default: load_registers(32'h0, 32'h0, 32'h0, 16'd0);
			endcase
			send_item(vfv_pkg::CMD_MESH, 8'd0, 8'd0, 8'd0, 16'h0000);
			send_item(vfv_pkg::CMD_MESH, 8'd15, 8'd15, 8'd15, 16'h0000);
			send_item(vfv_pkg::CMD_QUERY, 8'd15, 8'd15, 8'd15, 16'h0000);
		end
	endtask

	// Mostly neighborhood builds with meshes, plus revisits and noise;
	// halfway through the input side drains and the registers change
	task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
		int goal, half, r;
		bit swapped;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		load_registers(rand_origin(), rand_origin(), rand_origin(), rand_see());
		goal = items_counted + n_items;
		half = items_counted + n_items / 2;
		swapped = 1'b0;
		while (items_counted < goal) begin
			if (!swapped && items_counted >= half) begin
				load_registers(rand_origin(), rand_origin(), rand_origin(), rand_see());
				swapped = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 60)
				build_and_mesh();
			else if (r < 75)
				revisit_cell(1'b1);
			else if (r < 87)
				revisit_cell(1'b0);
			else
				send_noise();
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_register_writes();
		test_random_traffic(0, 0, 340);
		test_random_traffic(46, 0, 340);
		test_random_traffic(0, 46, 340);
		test_random_traffic(29, 29, 340);
		wait_results(SETTLE_CYCLES);
		$display("Sent %0d loads, %0d meshes, %0d queries and %0d ignored items.",
			n_loads, n_meshes, n_queries, n_ignored);
		$display("Checked %0d mesh records and %0d query answers over %0d register settings.",
			n_mesh_checked, n_query_checked, n_settings);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
